// File: rtl/wtsp_pkg.sv
// package: shared widths, register indexes and reset values for the projection block
`default_nettype none
package wtsp_pkg;
  localparam int COORD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int PIX_W      = 16;
  localparam int VIEW_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int QBITS      = 16;
  localparam int ROWS       = 3;

  // row order inside the datapath
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XB = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YA = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YB = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_WA = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_WB = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_W  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_H  = 4'd7;

  localparam logic [VIEW_W-1:0] VIEW_W_RST = 13'd1024;
  localparam logic [VIEW_W-1:0] VIEW_H_RST = 13'd768;
endpackage
`default_nettype wire

// File: rtl/wtsp_point_if.sv
// interface: world point channel
`default_nettype none
interface wtsp_point_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [wtsp_pkg::COORD_W-1:0]     pos_x;
  logic signed [wtsp_pkg::COORD_W-1:0]     pos_y;
  logic signed [wtsp_pkg::COORD_W-1:0]     pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// File: rtl/wtsp_screen_if.sv
// interface: screen result channel
`default_nettype none
interface wtsp_screen_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  visible;
  logic signed [wtsp_pkg::PIX_W-1:0]     screen_x;
  logic signed [wtsp_pkg::PIX_W-1:0]     screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

// File: rtl/wtsp_cfg_if.sv
// interface: register write channel
`default_nettype none
interface wtsp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wtsp_pkg::CFG_IDX_W-1:0]      index;
  logic [wtsp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/world_to_screen_projection_top.sv
// top level: pipelined world-to-screen projection with per-lane restoring divider
//
//  channel | dir | beat contents
//  pnt     | in  | pos_x, pos_y, pos_z (signed fixed point)
//  scr     | out | visible, screen_x, screen_y
//  cfg     | in  | index, data (register write, always ready)
//
// one point per cycle sustained while scr is ready; the 16 quotient bits of the pixel
// divide take one pipeline stage each and set the depth.
// each stage holds its beat only while the stage after it is full and stalled,
// so bubbles close up and the output register keeps its beat until taken.
// rst is synchronous: valid bits clear, coefficients go to 0, viewport to 1024x768.
`default_nettype none
module world_to_screen_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  wtsp_point_if.sink      pnt,
  wtsp_screen_if.source   scr,
  wtsp_cfg_if.sink        cfg
);
  localparam int QB  = wtsp_pkg::QBITS;
  localparam int CW  = 66 - FRAC_BITS;
  localparam int AW  = CW + 1;
  localparam int NW  = CW + 18;
  localparam int NS  = 7 + QB;
  localparam int RW  = wtsp_pkg::ROWS;
  localparam int PW  = wtsp_pkg::PIX_W;
  localparam int VW  = wtsp_pkg::VIEW_W;
  localparam logic signed [CW-1:0] THR = CW'(((1 << FRAC_BITS) + 5) / 10);

  typedef struct packed {
    logic                 vis;
    logic signed [NW-1:0] den;
    logic signed [NW-1:0] rem_x;
    logic signed [NW-1:0] rem_y;
    logic [QB-1:0]        q_x;
    logic [QB-1:0]        q_y;
    logic                 hi_x;
    logic                 lo_x;
    logic                 hi_y;
    logic                 lo_y;
  } div_t;

  // configuration registers
  logic [2*wtsp_pkg::COEF_W-1:0] coef_a [RW];
  logic [2*wtsp_pkg::COEF_W-1:0] coef_b [RW];
  logic [VW-1:0]                 view_w;
  logic [VW-1:0]                 view_h;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RW; r++) begin
        coef_a[r] <= '0;
        coef_b[r] <= '0;
      end
      view_w <= wtsp_pkg::VIEW_W_RST;
      view_h <= wtsp_pkg::VIEW_H_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        wtsp_pkg::REG_COEF_XA: coef_a[wtsp_pkg::ROW_X] <= cfg.data;
        wtsp_pkg::REG_COEF_XB: coef_b[wtsp_pkg::ROW_X] <= cfg.data;
        wtsp_pkg::REG_COEF_YA: coef_a[wtsp_pkg::ROW_Y] <= cfg.data;
        wtsp_pkg::REG_COEF_YB: coef_b[wtsp_pkg::ROW_Y] <= cfg.data;
        wtsp_pkg::REG_COEF_WA: coef_a[wtsp_pkg::ROW_W] <= cfg.data;
        wtsp_pkg::REG_COEF_WB: coef_b[wtsp_pkg::ROW_W] <= cfg.data;
        wtsp_pkg::REG_VIEW_W:  view_w <= cfg.data[VW-1:0];
        wtsp_pkg::REG_VIEW_H:  view_h <= cfg.data[VW-1:0];
        default: ;
      endcase
    end
  end

  // per-stage valid bits and advance enables
  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = scr.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pnt.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= pnt.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: nine coefficient by coordinate products
  logic signed [63:0] prod      [RW][3];
  logic signed [63:0] prod_next [RW][3];

  always_comb begin
    for (int r = 0; r < RW; r++) begin
      prod_next[r][0] = $signed(coef_a[r][31:0])  * pnt.pos_x;
      prod_next[r][1] = $signed(coef_a[r][63:32]) * pnt.pos_y;
      prod_next[r][2] = $signed(coef_b[r][31:0])  * pnt.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) prod <= prod_next;
  end

  // stage 2: floor shift and row sums plus translation
  logic signed [CW-1:0] clip      [RW];
  logic signed [CW-1:0] clip_next [RW];

  always_comb begin
    for (int r = 0; r < RW; r++) begin
      clip_next[r] = CW'(prod[r][0] >>> FRAC_BITS) + CW'(prod[r][1] >>> FRAC_BITS)
                   + CW'(prod[r][2] >>> FRAC_BITS) + CW'($signed(coef_b[r][63:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) clip <= clip_next;
  end

  // stage 3: visibility, numerators and common denominator
  logic                 vis3;
  logic signed [AW-1:0] ax3;
  logic signed [AW-1:0] ay3;
  logic signed [AW-1:0] den3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      vis3 <= clip[wtsp_pkg::ROW_W] >= THR;
      ax3  <= AW'(clip[wtsp_pkg::ROW_X]) + AW'(clip[wtsp_pkg::ROW_W]);
      ay3  <= AW'(clip[wtsp_pkg::ROW_W]) - AW'(clip[wtsp_pkg::ROW_Y]);
      den3 <= AW'(clip[wtsp_pkg::ROW_W]) <<< 1;
    end
  end

  // stage 4: scale numerators by viewport size
  logic signed [AW+VW:0] px_prod;
  logic signed [AW+VW:0] py_prod;
  logic                  vis4;
  logic signed [NW-1:0]  px4;
  logic signed [NW-1:0]  py4;
  logic signed [NW-1:0]  den4;

  always_comb begin
    px_prod = ax3 * $signed({1'b0, view_w});
    py_prod = ay3 * $signed({1'b0, view_h});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      vis4 <= vis3;
      px4  <= NW'(px_prod);
      py4  <= NW'(py_prod);
      den4 <= NW'(den3);
    end
  end

  // stage 5: offset so the quotient range starts at zero
  logic                 vis5;
  logic signed [NW-1:0] nx5;
  logic signed [NW-1:0] ny5;
  logic signed [NW-1:0] den5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      vis5 <= vis4;
      nx5  <= px4 + (den4 <<< (QB - 1));
      ny5  <= py4 + (den4 <<< (QB - 1));
      den5 <= den4;
    end
  end

  // stage 6: saturation flags, divider entry
  div_t d [QB+1];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d[0].vis   <= vis5;
      d[0].den   <= den5;
      d[0].rem_x <= nx5;
      d[0].rem_y <= ny5;
      d[0].q_x   <= '0;
      d[0].q_y   <= '0;
      d[0].lo_x  <= nx5 < 0;
      d[0].lo_y  <= ny5 < 0;
      d[0].hi_x  <= nx5 >= (den5 <<< QB);
      d[0].hi_y  <= ny5 >= (den5 <<< QB);
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic signed [NW-1:0] tx;
    logic signed [NW-1:0] ty;
    div_t                 d_next;

    always_comb begin
      tx = d[k].rem_x - (d[k].den <<< B);
      ty = d[k].rem_y - (d[k].den <<< B);
      d_next        = d[k];
      d_next.rem_x  = (tx >= 0) ? tx : d[k].rem_x;
      d_next.rem_y  = (ty >= 0) ? ty : d[k].rem_y;
      d_next.q_x[B] = tx >= 0;
      d_next.q_y[B] = ty >= 0;
    end

    always_ff @(posedge clk) begin
      if (en[6+k]) d[k+1] <= d_next;
    end
  end

  // output register: remove offset, saturate, blank when hidden
  logic                 vis_o;
  logic signed [PW-1:0] sx_o;
  logic signed [PW-1:0] sy_o;
  logic signed [PW-1:0] sx_next;
  logic signed [PW-1:0] sy_next;

  always_comb begin
    if (!d[QB].vis) begin
      sx_next = '0;
      sy_next = '0;
    end else begin
      if (d[QB].lo_x)      sx_next = {1'b1, {(PW-1){1'b0}}};
      else if (d[QB].hi_x) sx_next = {1'b0, {(PW-1){1'b1}}};
      else                 sx_next = {~d[QB].q_x[QB-1], d[QB].q_x[QB-2:0]};
      if (d[QB].lo_y)      sy_next = {1'b1, {(PW-1){1'b0}}};
      else if (d[QB].hi_y) sy_next = {1'b0, {(PW-1){1'b1}}};
      else                 sy_next = {~d[QB].q_y[QB-1], d[QB].q_y[QB-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      vis_o <= d[QB].vis;
      sx_o  <= sx_next;
      sy_o  <= sy_next;
    end
  end

  assign scr.valid    = v[NS-1];
  assign scr.visible  = vis_o;
  assign scr.screen_x = sx_o;
  assign scr.screen_y = sy_o;
endmodule
`default_nettype wire
